/* src/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [15:0] MaxUnitsReset = 16'd4095;
  localparam logic [15:0] SubstUnit     = 16'h003F;
  localparam logic [15:0] HiSurrBase    = 16'hD800;
  localparam logic [15:0] LoSurrBase    = 16'hDC00;
  localparam logic [20:0] SuppBase      = 21'h010000;

  // One decoded character waiting for the output side.
  typedef struct packed {
    logic [15:0] unit_hi;  // high surrogate, used only for pairs
    logic [15:0] unit_lo;  // single unit or low surrogate
    logic        pair;
    logic        subst;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

`default_nettype wire

/* src/u8u16_front.sv */
// Byte intake: UTF-8 sequence tracking, unit limit and character classification.
`default_nettype none

module u8u16_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic                 valid_i,
  output      logic                 ready_o,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 eos_i,
  input  wire logic                 full_i,
  output      logic                 push_o,
  output      u8u16_pkg::entry_t    entry_o
);

  logic [15:0] max_units_q;
  logic [20:0] pc_q, pc_d;
  logic [1:0]  due_q, due_d;
  logic [15:0] units_q, units_d;
  logic        stopped_q, stopped_d;

  logic        accept;
  logic        emit_req;
  logic [20:0] emit_cp;
  logic [20:0] pc_shift;
  logic [20:0] supp_off;

  assign ready_o  = !full_i;
  assign accept   = valid_i && !full_i;
  assign pc_shift = {pc_q[14:0], byte_i[5:0]};
  assign supp_off = emit_cp - u8u16_pkg::SuppBase;

  always_comb begin
    pc_d      = pc_q;
    due_d     = due_q;
    units_d   = units_q;
    stopped_d = stopped_q;
    emit_req  = 1'b0;
    emit_cp   = pc_shift;
    push_o    = 1'b0;
    entry_o   = '{unit_hi: '0, unit_lo: '0, pair: 1'b0, subst: 1'b0};

    if (accept && !stopped_q) begin
      if (due_q != 2'd0) begin
        due_d = due_q - 2'd1;
        pc_d  = pc_shift;
        if (due_q == 2'd1) begin
          emit_req = 1'b1;
          pc_d     = '0;
        end
      end else if (units_q >= max_units_q) begin
        stopped_d = 1'b1;
      end else if (!byte_i[7]) begin
        emit_req = 1'b1;
        emit_cp  = {13'd0, byte_i};
      end else if (byte_i[7:5] == 3'b110) begin
        pc_d  = {16'd0, byte_i[4:0]};
        due_d = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        pc_d  = {17'd0, byte_i[3:0]};
        due_d = 2'd2;
      end else if (byte_i[7:3] == 5'b11110) begin
        pc_d  = {18'd0, byte_i[2:0]};
        due_d = 2'd3;
      end else begin
        push_o        = 1'b1;
        entry_o.unit_lo = u8u16_pkg::SubstUnit;
        entry_o.subst = 1'b1;
        units_d       = units_q + 16'd1;
      end

      if (emit_req) begin
        if (emit_cp[20:16] != 5'd0) begin
          // A pair needs room for two units before the limit.
          if (({1'b0, units_q} + 17'd1) >= {1'b0, max_units_q}) begin
            stopped_d = 1'b1;
          end else begin
            push_o          = 1'b1;
            entry_o.unit_hi = u8u16_pkg::HiSurrBase + {6'd0, supp_off[19:10]};
            entry_o.unit_lo = u8u16_pkg::LoSurrBase + {6'd0, supp_off[9:0]};
            entry_o.pair    = 1'b1;
            units_d         = units_q + 16'd2;
          end
        end else begin
          push_o          = 1'b1;
          entry_o.unit_lo = emit_cp[15:0];
          units_d         = units_q + 16'd1;
        end
      end
    end

    if (accept && eos_i) begin
      pc_d      = '0;
      due_d     = '0;
      units_d   = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= u8u16_pkg::MaxUnitsReset;
      pc_q        <= '0;
      due_q       <= '0;
      units_q     <= '0;
      stopped_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_units_q <= cfg_wdata_i;
      end
      pc_q      <= pc_d;
      due_q     <= due_d;
      units_q   <= units_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

`default_nettype wire

/* src/u8u16_queue.sv */
// Small FIFO of decoded characters between the intake and the output side.
`default_nettype none

module u8u16_queue #(
  parameter int unsigned Depth = u8u16_pkg::QueueDepth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire u8u16_pkg::entry_t      entry_i,
  input  wire logic                   pop_i,
  output      u8u16_pkg::entry_t      head_o,
  output      u8u16_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8u16_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/u8u16_back.sv */
// Output side: splits surrogate pairs into two beats and holds the output register.
`default_nettype none

module u8u16_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire u8u16_pkg::entry_t      head_i,
  input  wire u8u16_pkg::queue_stat_t stat_i,
  output      logic                   pop_o,
  output      logic                   valid_o,
  input  wire logic                   ready_i,
  output      logic [15:0]            unit_o,
  output      logic                   last_o,
  output      logic                   subst_o
);

  logic        valid_q, valid_d;
  logic        phase_q, phase_d;
  logic [15:0] unit_q;
  logic        last_q, subst_q;
  logic        load;
  logic        high_half;

  assign load      = !stat_i.empty && (!valid_q || ready_i);
  assign high_half = head_i.pair && !phase_q;
  assign pop_o     = load && !high_half;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (load) begin
      valid_d = 1'b1;
      phase_d = high_half;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      unit_q  <= high_half ? head_i.unit_hi : head_i.unit_lo;
      last_q  <= !high_half;
      subst_q <= head_i.subst;
    end
  end

  assign valid_o = valid_q;
  assign unit_o  = unit_q;
  assign last_o  = last_q;
  assign subst_o = subst_q;

endmodule

`default_nettype wire

/* src/utf8_to_utf16_decoder.sv */
// UTF-8 to UTF-16 decoder top level with the character queue and checks.
//
// Input stream: one UTF-8 byte per beat in s_axis_tdata, s_axis_tlast on the
// final byte of a string. Output stream: one UTF-16 unit per beat, tlast on
// the last unit that an input byte produced, tuser on a '?' substitute.
// The front decodes one byte per cycle and pushes each finished character
// into a queue of QueueDepth entries; a byte is taken whenever the queue has
// room. The back splits a surrogate pair into two beats, so while the receiver
// is ready, output runs at one unit per cycle.
// A byte's units are written into the queue, then into the output register.
// Sustained rate, receiver ready: one byte per cycle, back-to-back surrogate
// pairs included, since a pair takes four input beats and only two output beats.
// When the receiver stalls, the output register holds its beat, the queue
// fills and s_axis_tready falls once it is full.
// Reset empties the queue, clears the string state and sets the limit to
// 4095 units; cfg_we_i writes a new limit.
`default_nettype none

module utf8_to_utf16_decoder #(
  // At least 2.
  parameter int unsigned QueueDepth = u8u16_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  wire logic        s_axis_tlast,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [15:0] unit
  output      logic        m_axis_tlast,
  output      logic        m_axis_tuser    // [0] is_substitute
);

  logic                   push;
  logic                   pop;
  u8u16_pkg::entry_t      push_entry;
  u8u16_pkg::entry_t      head;
  u8u16_pkg::queue_stat_t q_stat;

  u8u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .byte_i      (s_axis_tdata),
    .eos_i       (s_axis_tlast),
    .full_i      (q_stat.full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  u8u16_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  u8u16_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .stat_i  (q_stat),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .unit_o  (m_axis_tdata),
    .last_o  (m_axis_tlast),
    .subst_o (m_axis_tuser)
  );

  // The queue can never report full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.empty && q_stat.full))
    else $error("queue reports full and empty together");

  // A taken high surrogate is followed at once by its low half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("low surrogate did not follow its high half");

  // A substitute is always a single '?' unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tlast && (m_axis_tdata == u8u16_pkg::SubstUnit)))
    else $error("substitute beat is malformed");

  // Input is refused only when the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_stat.full)
    else $error("input stalled with room in the queue");

endmodule

`default_nettype wire

/* tb/sv/tb_utf8_to_utf16_decoder.sv */
// Self-checking testbench for the UTF-8 to UTF-16 decoder with a predicting scoreboard.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder;

  localparam int unsigned PhaseItems = 115;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [15:0] unit;
    logic        subst;
    logic        last;
  } utf16_unit_t;

  // Predicts the UTF-16 units of every accepted byte and checks the output beats.
  class utf16_scoreboard;
    logic [15:0]  max_units;
    logic [20:0]  partial;
    logic [1:0]   due;
    logic [15:0]  emitted;
    bit           halted;
    utf16_unit_t  units_due[$];
    int unsigned  errors;
    int unsigned  reported;

    function new();
      max_units = u8u16_pkg::MaxUnitsReset;
      errors    = 0;
      reported  = 0;
      clear_string();
    endfunction

    function void clear_string();
      partial = '0;
      due     = '0;
      emitted = '0;
      halted  = 1'b0;
    endfunction

    function void set_limit(logic [15:0] v);
      max_units = v;
    endfunction

    function int pending();
      return units_due.size();
    endfunction

    function void push_unit(logic [15:0] u, logic sub, logic last);
      utf16_unit_t e;
      e.unit  = u;
      e.subst = sub;
      e.last  = last;
      units_due.push_back(e);
    endfunction

    function void emit_code(logic [20:0] cp);
      logic [20:0] v;
      if (cp > 21'h00FFFF) begin
        v = cp - u8u16_pkg::SuppBase;
        // A surrogate pair needs room for two units.
        if ({1'b0, emitted} + 17'd1 >= {1'b0, max_units}) begin
          halted = 1'b1;
          return;
        end
        push_unit(u8u16_pkg::HiSurrBase + {6'b0, v[19:10]}, 1'b0, 1'b0);
        push_unit(u8u16_pkg::LoSurrBase + {6'b0, v[9:0]}, 1'b0, 1'b1);
        emitted = emitted + 16'd2;
      end else begin
        push_unit(cp[15:0], 1'b0, 1'b1);
        emitted = emitted + 16'd1;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic eos);
      if (!halted) begin
        if (due != 2'd0) begin
          // Any byte counts as a continuation; only its low six bits are kept.
          partial = {partial[14:0], b[5:0]};
          due     = due - 2'd1;
          if (due == 2'd0) begin
            emit_code(partial);
            partial = '0;
          end
        end else if (emitted >= max_units) begin
          halted = 1'b1;
        end else if (!b[7]) begin
          emit_code({13'b0, b});
        end else if (b[7:5] == 3'b110) begin
          partial = {16'b0, b[4:0]};
          due     = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          partial = {17'b0, b[3:0]};
          due     = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          partial = {18'b0, b[2:0]};
          due     = 2'd3;
        end else begin
          push_unit(u8u16_pkg::SubstUnit, 1'b1, 1'b1);
          emitted = emitted + 16'd1;
        end
      end
      if (eos) clear_string();
    endfunction

    function void check_unit(logic [15:0] u, logic sub, logic last);
      utf16_unit_t e;
      if (units_due.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected beat: unit %h sub %b last %b", u, sub, last);
        end
        return;
      end
      e = units_due.pop_front();
      if (e.unit !== u || e.subst !== sub || e.last !== last) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: unit exp %h got %h, sub exp %b got %b, last exp %b got %b",
                   e.unit, u, e.subst, sub, e.last, last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  utf16_scoreboard sb;
  bit              calm;
  int unsigned     cycles;
  logic [8:0]      byte_plan[$];  // {tlast, byte}

  utf8_to_utf16_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat was taken.
  task automatic send_beat(input logic [7:0] b, input logic eos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_byte(b, eos);
    @(negedge clk_i);
  endtask

  // Holds the input side until every predicted unit has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_limit(v);
  endtask

  // Mostly well-formed characters, with some stray bytes and cut-off sequences.
  task automatic plan_string();
    int n;
    int r;
    int len;
    int conts;
    logic [7:0] lead;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        byte_plan.push_back({1'b0, 8'($urandom_range(0, 255))});
      end else begin
        len = (r < 30) ? $urandom_range(2, 4) : $urandom_range(1, 4);
        case (len)
          1: lead = 8'($urandom_range(0, 127));
          2: lead = 8'hC0 | 8'($urandom_range(0, 31));
          3: lead = 8'hE0 | 8'($urandom_range(0, 15));
          default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        conts = (r < 30) ? $urandom_range(0, len - 2) : len - 1;
        byte_plan.push_back({1'b0, lead});
        for (int k = 0; k < conts; k++)
          byte_plan.push_back({1'b0, 8'h80 | 8'($urandom_range(0, 63))});
      end
    end
    byte_plan[byte_plan.size() - 1][8] = 1'b1;
  endtask

  // Output side: a random stall before each beat.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_unit(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [8:0]  directed[$];
    logic [8:0]  beat;
    logic [15:0] limit;
    int unsigned sent;
    directed = '{9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF,
                 9'h0F0, 9'h090, 9'h080, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
                 9'h080, 9'h1FF, 9'h0F8, 9'h0C3, 9'h041, 9'h0E2, 9'h182};
    sb            = new();
    calm          = 1'b0;
    cycles        = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Extremes and special cases under the reset limit.
    foreach (directed[i]) send_beat(directed[i][7:0], directed[i][8]);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        0: limit = 16'd1;
        1: limit = 16'd65535;
        2: limit = 16'd2;
        3: limit = 16'd3;
        4: limit = 16'd7;
        default: limit = (p % 2 == 0) ? 16'($urandom_range(1, 12))
                                       : 16'($urandom_range(1, 65535));
      endcase
      write_limit(limit);
      sent = 0;
      // Odd phases may stop inside a string, so the next limit applies mid-string.
      while (sent < PhaseItems || (p % 2 == 0 && byte_plan.size() != 0)) begin
        if (byte_plan.size() == 0) begin
          plan_string();
          calm = ($urandom_range(0, 7) == 0);
          if ($urandom_range(0, 9) == 0) wait_drained();
        end
        beat = byte_plan.pop_front();
        send_beat(beat[7:0], beat[8]);
        sent++;
      end
    end

    wait_drained();
    repeat (12) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
